>>> hw/rtl/htbd_pkg.sv
// Shared types and constants for the code tree bit decoder.
package htbd_pkg;

	localparam logic [1:0] MODE_CLEAR  = 2'd0;
	localparam logic [1:0] MODE_DEFINE = 2'd1;
	localparam logic [1:0] MODE_DECODE = 2'd2;

	localparam int SYM_W  = 8;
	localparam int BITS_W = 32;

	typedef struct packed {
		logic [1:0]        mode;
		logic [SYM_W-1:0]  symbol;
		logic [5:0]        code_length;
		logic [BITS_W-1:0] code_bits;
		logic              data_bit;
	} in_t;

	typedef struct packed {
		logic [SYM_W-1:0] symbol_out;
		logic             error;
	} out_t;

	typedef struct packed {
		logic clear;
		logic dec_issue;
		logic dec_land;
		logic def_load;
		logic def_step;
		logic def_read;
		logic def_new;
	} cmd_t;

	typedef struct packed {
		logic slot_free;
		logic dec_miss;
		logic rem_zero;
		logic child_hit;
		logic full;
	} sts_t;

endpackage

>>> hw/rtl/htbd_datapath.sv
// Node store, walk registers, code bit state and result register.
module htbd_datapath #(
	parameter int NODE_COUNT   = 512,
	parameter int MAX_CODE_LEN = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  htbd_pkg::in_t in_data,
	input  htbd_pkg::cmd_t cmd,
	output htbd_pkg::sts_t sts,
	input  logic          out_ready,
	output logic          out_valid,
	output htbd_pkg::out_t out_data
);

	localparam int IDX_W  = $clog2(NODE_COUNT);
	localparam int USED_W = $clog2(NODE_COUNT + 1);
	localparam int LEN_W  = $clog2(MAX_CODE_LEN + 1);

	typedef struct packed {
		logic [IDX_W-1:0]          left;
		logic [IDX_W-1:0]          right;
		logic [htbd_pkg::SYM_W-1:0] sym;
	} node_t;

	node_t mem [NODE_COUNT];

	node_t                          root_q;
	node_t                          wnode_q;
	node_t                          node_q;
	node_t                          rd_q;
	logic [IDX_W-1:0]               walk_q;
	logic [IDX_W-1:0]               nxt_q;
	logic [IDX_W-1:0]               cur_q;
	logic [USED_W-1:0]              nodes_used_q;
	logic [LEN_W-1:0]               rem_q;
	logic [htbd_pkg::SYM_W-1:0]     sym_q;
	logic [htbd_pkg::BITS_W-1:0]    bits_q;
	logic                           out_valid_q;
	htbd_pkg::out_t                 out_q;

	node_t            walk_node;
	logic [IDX_W-1:0] dnxt;
	logic [6:0]       pos;
	logic             code_bit;
	logic [IDX_W-1:0] def_child;
	logic [IDX_W-1:0] new_idx;
	logic             hit;
	logic             leaf;
	logic             we;
	logic [IDX_W-1:0] waddr;
	node_t            wdata;
	logic             re;
	logic [IDX_W-1:0] raddr;
	logic             load_out;
	htbd_pkg::out_t   out_d;
	logic [LEN_W-1:0] len_sat;

	assign walk_node = (walk_q == '0) ? root_q : wnode_q;
	assign dnxt      = in_data.data_bit ? walk_node.right : walk_node.left;
	assign pos       = 7'(rem_q) - 7'd1;
	assign code_bit  = (pos < 7'd32) ? bits_q[pos[4:0]] : 1'b0;
	assign def_child = code_bit ? node_q.right : node_q.left;
	assign new_idx   = nodes_used_q[IDX_W-1:0];
	assign leaf      = (rd_q.left == '0) && (rd_q.right == '0);

	assign sts.slot_free = !out_valid_q || out_ready;
	assign sts.dec_miss  = (dnxt == '0);
	assign sts.rem_zero  = (rem_q == '0);
	assign sts.child_hit = (def_child != '0);
	assign sts.full      = (nodes_used_q >= USED_W'(NODE_COUNT));

	assign hit = cmd.def_step && !sts.rem_zero && sts.child_hit;

	assign len_sat = ({1'b0, in_data.code_length} > 7'(MAX_CODE_LEN)) ?
		LEN_W'(MAX_CODE_LEN) : LEN_W'(in_data.code_length);

	always_comb begin
		we    = 1'b0;
		waddr = cur_q;
		wdata = node_q;
		if (cmd.def_step) begin
			if (sts.rem_zero) begin
				we        = 1'b1;
				wdata.sym = sym_q;
			end else if (!sts.child_hit && !sts.full) begin
				we = 1'b1;
				if (code_bit) begin
					wdata.right = new_idx;
				end else begin
					wdata.left = new_idx;
				end
			end
		end
		if (cmd.def_new) begin
			we    = 1'b1;
			waddr = nxt_q;
			wdata = '0;
		end
	end

	always_comb begin
		re    = 1'b0;
		raddr = def_child;
		if (cmd.dec_issue && !sts.dec_miss) begin
			re    = 1'b1;
			raddr = dnxt;
		end else if (hit) begin
			re = 1'b1;
		end
	end

	always_comb begin
		load_out         = 1'b0;
		out_d.symbol_out = '0;
		out_d.error      = 1'b1;
		if (cmd.dec_issue && sts.dec_miss) begin
			load_out = 1'b1;
		end else if (cmd.dec_land && leaf) begin
			load_out         = 1'b1;
			out_d.symbol_out = rd_q.sym;
			out_d.error      = 1'b0;
		end else if (cmd.def_step && !sts.rem_zero && !sts.child_hit && sts.full) begin
			load_out = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we && waddr != '0) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q       <= '0;
			nodes_used_q <= USED_W'(1);
			walk_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.clear) begin
				root_q       <= '0;
				nodes_used_q <= USED_W'(1);
				walk_q       <= '0;
			end else begin
				if (we && waddr == '0) begin
					root_q <= wdata;
				end
				if (cmd.def_new) begin
					nodes_used_q <= nodes_used_q + USED_W'(1);
				end
				if (cmd.dec_issue && sts.dec_miss) begin
					walk_q <= '0;
				end else if (cmd.dec_land) begin
					walk_q <= leaf ? '0 : nxt_q;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.dec_land && !leaf) begin
			wnode_q <= rd_q;
		end else if (we && waddr == walk_q && walk_q != '0) begin
			wnode_q <= wdata;
		end
		if (cmd.dec_issue) begin
			nxt_q <= dnxt;
		end else if (cmd.def_step) begin
			nxt_q <= new_idx;
		end
		if (cmd.def_load) begin
			cur_q  <= '0;
			node_q <= root_q;
			rem_q  <= len_sat;
			sym_q  <= in_data.symbol;
			bits_q <= in_data.code_bits;
		end else begin
			if (hit) begin
				cur_q <= def_child;
				rem_q <= rem_q - LEN_W'(1);
			end
			if (cmd.def_read) begin
				node_q <= rd_q;
			end
			if (cmd.def_new) begin
				cur_q  <= nxt_q;
				node_q <= '0;
				rem_q  <= rem_q - LEN_W'(1);
			end
		end
		if (load_out) begin
			out_q <= out_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		nodes_used_q != '0 && nodes_used_q <= USED_W'(NODE_COUNT))
		else $error("node count out of range");

	a_walk_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		USED_W'(walk_q) < nodes_used_q)
		else $error("walk position beyond allocated nodes");

	a_new_not_root: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.def_new |-> nxt_q != '0)
		else $error("node init aimed at root");

	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_valid_q || out_ready))
		else $error("result overwrites pending transfer");

endmodule

>>> hw/rtl/htbd_ctrl.sv
// Controller state machine sequencing clear, define and decode operations.
module htbd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [1:0]     mode,
	input  htbd_pkg::sts_t sts,
	output htbd_pkg::cmd_t cmd
);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_DEC_RD   = 3'd1;
	localparam logic [2:0] ST_DEF_STEP = 3'd2;
	localparam logic [2:0] ST_DEF_RD   = 3'd3;
	localparam logic [2:0] ST_DEF_NEW  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       accept;

	assign in_ready = (state_q == ST_IDLE) && sts.slot_free;
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (mode)
						htbd_pkg::MODE_CLEAR: begin
							cmd.clear = 1'b1;
						end
						htbd_pkg::MODE_DEFINE: begin
							cmd.def_load = 1'b1;
							state_d      = ST_DEF_STEP;
						end
						htbd_pkg::MODE_DECODE: begin
							cmd.dec_issue = 1'b1;
							if (!sts.dec_miss) begin
								state_d = ST_DEC_RD;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_DEC_RD: begin
				cmd.dec_land = 1'b1;
				state_d      = ST_IDLE;
			end
			ST_DEF_STEP: begin
				cmd.def_step = 1'b1;
				if (sts.rem_zero) begin
					state_d = ST_IDLE;
				end else if (sts.child_hit) begin
					state_d = ST_DEF_RD;
				end else if (sts.full) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_DEF_NEW;
				end
			end
			ST_DEF_RD: begin
				cmd.def_read = 1'b1;
				state_d      = ST_DEF_STEP;
			end
			ST_DEF_NEW: begin
				cmd.def_new = 1'b1;
				state_d     = ST_DEF_STEP;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> state_q == ST_IDLE)
		else $error("transfer taken while busy");

	a_define_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && mode == htbd_pkg::MODE_DEFINE) |=> state_q == ST_DEF_STEP)
		else $error("define did not start");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("conflicting commands");

endmodule

>>> hw/rtl/huffman_tree_bit_decoder.sv
// Top level of the bitwise code tree decoder.
// Input channel (in_valid/in_ready/in_data) carries one command per transfer:
//   clear the tree, define one code (symbol, code_length, code_bits, MSB first),
//   or decode one data bit. Output channel (out_valid/out_ready/out_data)
//   carries at most one result per command: a decoded symbol, or error set on
//   a missing child or a full node store. Clear and successful defines give none.
// Steps: a decode bit issues one node store read per tree step, then lands
//   it; a bit that hits a missing child ends without a read. A define loads
//   the code, then per code bit does step and read, or step and node init,
//   then a last step to store the symbol. Clear acts in the cycle it is taken.
// Reset leaves a bare root and the walk at the root; no sweep of the store is
//   needed, since entries are written when allocated.
// Results sit in an output register; a command is taken only when that
//   register is empty or being drained, so a stalled receiver holds the input
//   side off until its pending transfer is taken.
module huffman_tree_bit_decoder #(
	parameter int NODE_COUNT   = 512,
	parameter int MAX_CODE_LEN = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  htbd_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output htbd_pkg::out_t out_data
);

	htbd_pkg::cmd_t cmd;
	htbd_pkg::sts_t sts;

	htbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.mode     (in_data.mode),
		.sts      (sts),
		.cmd      (cmd)
	);

	htbd_datapath #(
		.NODE_COUNT   (NODE_COUNT),
		.MAX_CODE_LEN (MAX_CODE_LEN)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule
